### src/tbas_pkg.sv
package tbas_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 17;
    localparam int GAIN_W   = 16;
    localparam int TARGET_W = 8;
    localparam int NUM_BANDS = 3;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32767;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd255;
    // largest value the smoothed gain can settle at (255 << 8)
    localparam logic [GAIN_W-1:0] GAIN_CEIL = 16'hFF00;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASS   = 2'd0,
        CFG_MID    = 2'd1,
        CFG_TREBLE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        BAND_BASS   = 2'd0,
        BAND_MID    = 2'd1,
        BAND_TREBLE = 2'd2
    } band_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [PEAK_W-1:0]          peak_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [TARGET_W-1:0]        target_t;

endpackage

### src/three_band_audio_splitter.sv
// Frames from s_* pass stage by stage to m_*; throughput is one frame per cycle
// while m_tready does not stall. The three stages (window sums, gain multiply,
// mix and peak) each hold one frame and hand on as soon as the next stage frees.
// Reset (aresetn low, synchronous) clears the frame history, window sums,
// smoothed gains, block peaks and pipeline valids; gain targets return to 255.
module three_band_audio_splitter #(
    parameter int LONG_WINDOW  = 64,
    parameter int SHORT_WINDOW = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tbas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbas_pkg::TARGET_W-1:0]  cfg_data,
    // frame input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // left_sample, right_sample
    input  logic                           s_tlast,  // block_end
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [167:0]                   m_tdata,  // bass_left, bass_right, mid_left,
                                                     // mid_right, treble_left, treble_right,
                                                     // mix_left, mix_right, peak_left,
                                                     // peak_right, zero pad
    output logic                           m_tlast   // block_done
);
    import tbas_pkg::*;

    localparam int DELAY       = LONG_WINDOW / 2;
    localparam int SHORT_START = DELAY - SHORT_WINDOW / 2;
    localparam int SH_IN_B     = SHORT_START % LONG_WINDOW;
    localparam int SH_OUT_B    = (SHORT_START + SHORT_WINDOW) % LONG_WINDOW;
    localparam int DLY_B       = DELAY % LONG_WINDOW;
    localparam int SH_IN_I     = (SH_IN_B == 0) ? 0 : SH_IN_B - 1;
    localparam int SH_OUT_I    = (SH_OUT_B == 0) ? 0 : SH_OUT_B - 1;
    localparam int DLY_I       = (DLY_B == 0) ? 0 : DLY_B - 1;

    localparam int LSW = SAMPLE_W + $clog2(LONG_WINDOW);
    localparam int SSW = SAMPLE_W + $clog2(SHORT_WINDOW);
    localparam int LS  = $clog2(LONG_WINDOW + 1) - 1;
    localparam int SS  = $clog2(SHORT_WINDOW + 1) - 1;
    localparam int BLW = LSW - LS;
    localparam int SAW = SSW - SS;
    localparam int DW  = ((BLW > SAW) ? BLW : SAW) + 2;
    localparam int PW  = DW + TARGET_W + 1;
    localparam int QW  = PW - 8;

    // ---------------------------------------------------------------- config
    target_t target_reg [NUM_BANDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                target_reg[i] <= TARGET_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_BASS:   target_reg[BAND_BASS]   <= cfg_data;
                CFG_MID:    target_reg[BAND_MID]    <= cfg_data;
                CFG_TREBLE: target_reg[BAND_TREBLE] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic in_fire, ld2, ld3;

    assign rdy3    = !v3_reg || m_tready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_fire = s_tvalid && s_tready;
    assign ld2     = v1_reg && rdy2;
    assign ld3     = v2_reg && rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_fire;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ----------------------------------------------- stage 1: history and sums
    // hist_reg[j] holds the frame j+1 behind the incoming one
    logic [31:0] hist_reg [LONG_WINDOW];
    logic signed [LSW-1:0] long_reg  [2];
    logic signed [SSW-1:0] short_reg [2];
    gain_t gain_reg [NUM_BANDS];

    logic [31:0] oldest, sh_in, sh_out, dly;
    logic signed [LSW-1:0] long_next  [2];
    logic signed [SSW-1:0] short_next [2];
    logic signed [BLW-1:0] bl [2];
    logic signed [SAW-1:0] sa [2];
    logic signed [DW-1:0]  op_next [2][NUM_BANDS];
    gain_t gain_next [NUM_BANDS];
    logic [GAIN_W+3:0] gain_acc [NUM_BANDS];

    assign oldest = hist_reg[LONG_WINDOW-1];
    assign sh_in  = (SH_IN_B == 0)  ? s_tdata : hist_reg[SH_IN_I];
    assign sh_out = (SH_OUT_B == 0) ? s_tdata : hist_reg[SH_OUT_I];
    assign dly    = (DLY_B == 0)    ? s_tdata : hist_reg[DLY_I];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            long_next[c] = long_reg[c]
                + LSW'($signed(s_tdata[16*c +: 16]))
                - LSW'($signed(oldest[16*c +: 16]));
            short_next[c] = short_reg[c]
                + SSW'($signed(sh_in[16*c +: 16]))
                - SSW'($signed(sh_out[16*c +: 16]));
            // floor shift: keep the upper bits
            bl[c] = long_next[c][LSW-1:LS];
            sa[c] = short_next[c][SSW-1:SS];
            op_next[c][BAND_BASS]   = DW'(bl[c]);
            op_next[c][BAND_MID]    = DW'(sa[c]) - DW'(bl[c]);
            op_next[c][BAND_TREBLE] = DW'($signed(dly[16*c +: 16])) - DW'(sa[c]);
        end
        for (int i = 0; i < NUM_BANDS; i++) begin
            // g*15 + target*256, then >> 4
            gain_acc[i] = {gain_reg[i], 4'b0000} - {4'b0000, gain_reg[i]}
                        + {4'b0000, target_reg[i], 8'h00};
            gain_next[i] = gain_acc[i][GAIN_W+3:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < LONG_WINDOW; j++) begin
                hist_reg[j] <= '0;
            end
            for (int c = 0; c < 2; c++) begin
                long_reg[c]  <= '0;
                short_reg[c] <= '0;
            end
            for (int i = 0; i < NUM_BANDS; i++) begin
                gain_reg[i] <= '0;
            end
        end else if (in_fire) begin
            hist_reg[0] <= s_tdata;
            for (int j = 1; j < LONG_WINDOW; j++) begin
                hist_reg[j] <= hist_reg[j-1];
            end
            for (int c = 0; c < 2; c++) begin
                long_reg[c]  <= long_next[c];
                short_reg[c] <= short_next[c];
            end
            for (int i = 0; i < NUM_BANDS; i++) begin
                gain_reg[i] <= gain_next[i];
            end
        end
    end

    logic signed [DW-1:0] op_reg [2][NUM_BANDS];
    target_t              mul_reg [NUM_BANDS];  // gain before this frame's update, >> 8
    logic                 bend1_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg    <= op_next;
            bend1_reg <= s_tlast;
            for (int i = 0; i < NUM_BANDS; i++) begin
                mul_reg[i] <= gain_reg[i][GAIN_W-1:8];
            end
        end
    end

    // ------------------------------------------------ stage 2: scale bands
    function automatic sample_t sat_band(input logic signed [QW-1:0] x);
        if (x > QW'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (x < QW'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return x[SAMPLE_W-1:0];
    endfunction

    logic signed [PW-1:0] prod [2][NUM_BANDS];
    sample_t              band_next [2][NUM_BANDS];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                prod[c][i] = PW'($signed({1'b0, mul_reg[i]})) * PW'(op_reg[c][i]);
                band_next[c][i] = sat_band(prod[c][i][PW-1:8]);
            end
        end
    end

    sample_t band_reg [2][NUM_BANDS];
    logic    bend2_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            band_reg  <= band_next;
            bend2_reg <= bend1_reg;
        end
    end

    // ------------------------------------------------ stage 3: mix and peaks
    peak_t peak_reg [2];
    logic signed [SAMPLE_W+1:0] mix_sum [2];
    logic signed [SAMPLE_W+1:0] mix_neg [2];
    peak_t   mix_abs  [2];
    peak_t   peak_cur [2];
    sample_t mix_next [2];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            mix_sum[c] = (SAMPLE_W+2)'(band_reg[c][BAND_BASS])
                       + (SAMPLE_W+2)'(band_reg[c][BAND_MID])
                       + (SAMPLE_W+2)'(band_reg[c][BAND_TREBLE]);
            mix_neg[c] = -mix_sum[c];
            mix_abs[c] = mix_sum[c][SAMPLE_W+1] ? mix_neg[c][PEAK_W-1:0]
                                                : mix_sum[c][PEAK_W-1:0];
            peak_cur[c] = (mix_abs[c] > peak_reg[c]) ? mix_abs[c] : peak_reg[c];
            if (mix_sum[c] > (SAMPLE_W+2)'(SAT_MAX)) begin
                mix_next[c] = SAT_MAX;
            end else if (mix_sum[c] < (SAMPLE_W+2)'(SAT_MIN)) begin
                mix_next[c] = SAT_MIN;
            end else begin
                mix_next[c] = mix_sum[c][SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg[0] <= '0;
            peak_reg[1] <= '0;
        end else if (ld3) begin
            for (int c = 0; c < 2; c++) begin
                peak_reg[c] <= bend2_reg ? '0 : peak_cur[c];
            end
        end
    end

    sample_t out_band_reg [2][NUM_BANDS];
    sample_t out_mix_reg  [2];
    peak_t   out_peak_reg [2];
    logic    bend3_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            out_band_reg <= band_reg;
            out_mix_reg  <= mix_next;
            out_peak_reg <= peak_cur;
            bend3_reg    <= bend2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tlast  = bend3_reg;
    assign m_tdata  = {6'd0,
                       out_peak_reg[1], out_peak_reg[0],
                       out_mix_reg[1], out_mix_reg[0],
                       out_band_reg[1][BAND_TREBLE], out_band_reg[0][BAND_TREBLE],
                       out_band_reg[1][BAND_MID], out_band_reg[0][BAND_MID],
                       out_band_reg[1][BAND_BASS], out_band_reg[0][BAND_BASS]};

`ifndef ASSERT_OFF
    // input only backs up when every stage is full and the sink stalls
    a_stall_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && m_tvalid && !m_tready))
        else $error("input stalled with a free pipeline stage");

    // peaks restart after the closing beat of a block passes the mix stage
    a_peak_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld3 && bend2_reg) |=> (peak_reg[0] == '0 && peak_reg[1] == '0))
        else $error("block peaks not cleared at block end");

    // smoothing can never push a gain past the largest target
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (gain_reg[BAND_BASS] <= GAIN_CEIL) && (gain_reg[BAND_MID] <= GAIN_CEIL)
        && (gain_reg[BAND_TREBLE] <= GAIN_CEIL))
        else $error("smoothed gain out of range");

    // reported peak covers the magnitude of the frame's saturated mix
    a_peak_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        ld3 |=> (out_mix_reg[0][SAMPLE_W-1]
                 ? (out_peak_reg[0] >= PEAK_W'(-out_mix_reg[0]))
                 : (out_peak_reg[0] >= PEAK_W'(out_mix_reg[0]))))
        else $error("peak below saturated mix magnitude");
`endif

endmodule
